// ===== hdl/logistic_map_bifurcation_point_unit_assert.svh =====
// Assertion macros for the bifurcation point unit
`ifndef LOGISTIC_MAP_BIFURCATION_POINT_UNIT_ASSERT_SVH
`define LOGISTIC_MAP_BIFURCATION_POINT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LMBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LMBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lmbp_pkg.sv =====
`timescale 1ns / 1ps

package lmbp_pkg;

  localparam int VALUE_FRACTION_BITS = 31;
  localparam int RATE_FRACTION_BITS  = 29;

  localparam int ITER_W    = 20;
  localparam int DIM_W     = 16;
  localparam int RATE_W    = 32;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 64;
  localparam int NUM_W     = 48;
  localparam int Y_W       = DIM_W + 1;
  localparam int XC_W      = PROD_W - RATE_FRACTION_BITS;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int PC_W      = 4;

  localparam logic [ITER_W-1:0] DIV_STEPS = ITER_W'(NUM_W);

  localparam logic [VAL_W-1:0]  VALUE_ONE = VAL_W'(64'd1 << VALUE_FRACTION_BITS);
  localparam logic [RATE_W-1:0] RATE_MAX  = 32'h8000_0000;

  localparam logic [ITER_W-1:0] ITER_COUNT_RST   = 20'd10000;
  localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = 16'd26500;
  localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = 16'd20960;
  localparam logic [RATE_W-1:0] RATE_START_RST   = 32'd1879048192;
  localparam logic [RATE_W-1:0] RATE_END_RST     = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITER_COUNT   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_RATE_START   = 3'd3,
    REG_RATE_END     = 3'd4
  } cfg_reg_t;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t S_IDLE = 4'd0;
  localparam pc_t S_CHK  = 4'd1;
  localparam pc_t S_MXX  = 4'd2;
  localparam pc_t S_MAP  = 4'd3;
  localparam pc_t S_UPD  = 4'd4;
  localparam pc_t S_HX   = 4'd5;
  localparam pc_t S_ROW  = 4'd6;
  localparam pc_t S_COL  = 4'd7;
  localparam pc_t S_DIVI = 4'd8;
  localparam pc_t S_DIV  = 4'd9;
  localparam pc_t S_SAT  = 4'd10;
  localparam pc_t S_EMIT = 4'd11;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_XMX, MUL_AP, MUL_HX, MUL_WA
  } mul_sel_t;

  typedef enum logic [2:0] {
    CNT_HOLD, CNT_ONE, CNT_INC, CNT_DIV, CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    J_NEVER, J_ALWAYS, J_ITER_DONE, J_ITER_MORE, J_Y_ZERO, J_COL_ZERO, J_DIV_MORE
  } jump_t;

  typedef enum logic [1:0] {
    W_NONE, W_NO_INPUT, W_OUT_BUSY
  } wait_t;

  typedef struct packed {
    logic     in_ready;
    wait_t    wait_on;
    jump_t    jump;
    pc_t      target;
    mul_sel_t mul_sel;
    cnt_op_t  cnt_op;
    logic     ld_in;
    logic     ld_x;
    logic     ld_y;
    logic     ld_den;
    logic     clr_q;
    logic     ld_dvd;
    logic     div_step;
    logic     ld_col;
    logic     ld_out;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic iter_done;
    logic iter_more;
    logic y_zero;
    logic col_zero;
    logic div_more;
  } dp_status_t;

  localparam ctl_word_t CTL_NOP = '0;

  function automatic ctl_word_t ucode(pc_t pc);
    ctl_word_t w;
    w = CTL_NOP;
    case (pc)
      S_IDLE: begin
        w.in_ready = 1'b1;
        w.wait_on  = W_NO_INPUT;
        w.ld_in    = 1'b1;
        w.cnt_op   = CNT_ONE;
      end
      S_CHK: begin
        w.jump   = J_ITER_DONE;
        w.target = S_HX;
      end
      S_MXX: begin
        w.mul_sel = MUL_XMX;
      end
      S_MAP: begin
        w.mul_sel = MUL_AP;
      end
      S_UPD: begin
        w.ld_x   = 1'b1;
        w.cnt_op = CNT_INC;
        w.jump   = J_ITER_MORE;
        w.target = S_MXX;
      end
      S_HX: begin
        w.mul_sel = MUL_HX;
      end
      S_ROW: begin
        w.ld_y   = 1'b1;
        w.jump   = J_Y_ZERO;
        w.target = S_IDLE;
      end
      S_COL: begin
        w.ld_den  = 1'b1;
        w.clr_q   = 1'b1;
        w.mul_sel = MUL_WA;
        w.jump    = J_COL_ZERO;
        w.target  = S_SAT;
      end
      S_DIVI: begin
        w.ld_dvd = 1'b1;
        w.cnt_op = CNT_DIV;
      end
      S_DIV: begin
        w.div_step = 1'b1;
        w.cnt_op   = CNT_DEC;
        w.jump     = J_DIV_MORE;
        w.target   = S_DIV;
      end
      S_SAT: begin
        w.ld_col = 1'b1;
      end
      S_EMIT: begin
        w.wait_on = W_OUT_BUSY;
        w.ld_out  = 1'b1;
        w.jump    = J_ALWAYS;
        w.target  = S_IDLE;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/logistic_map_bifurcation_point_unit.sv =====
// Logistic map bifurcation point unit. Each request carries a growth rate a (29 fraction
// bits, clamped to 4.0) and a start value x0 (31 fraction bits, clamped to 1.0). The unit
// applies x = a*x*(1-x) iteration_count-1 times, truncating after each multiply, then returns
// plot_row = image_height - floor(image_height*x), the column
// floor(image_width*(a-rate_start)/(rate_end-rate_start)) saturated to [0, image_width], and
// the final x. A request whose floor(image_height*x) is zero yields no result. One request
// is worked at a time. The map loop takes three steps per iteration on the single 32x32
// multiplier; the 48-step column divide makes one quotient bit per cycle and is skipped when
// the column is zero. The next request can be taken in the cycle after the result is loaded
// into the output register, even if it is not yet taken. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata by the user only while the unit is idle; it is not enforced.
`timescale 1ns / 1ps
`include "logistic_map_bifurcation_point_unit_assert.svh"

module logistic_map_bifurcation_point_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // growth_rate [31:0], start_value [63:32]
  input  logic [63:0]                       in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // plot_row [15:0], plot_column [31:16], final_value [63:32]
  output logic [63:0]                       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [lmbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmbp_pkg::CFG_W-1:0]        cfg_wdata
);
  import lmbp_pkg::*;

  ctl_word_t  ctl;
  dp_status_t status;

  logic [ITER_W-1:0] iter_count_r, iter_count_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [RATE_W-1:0] rate_start_r, rate_start_nxt;
  logic [RATE_W-1:0] rate_end_r, rate_end_nxt;

  logic [RATE_W-1:0] a_r, a_nxt;
  logic [VAL_W-1:0]  x_r, x_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0]  y_r, y_nxt;
  logic [RATE_W-1:0] den_r, den_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]  dvd_r, dvd_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DIM_W-1:0]  out_row_r, out_row_nxt;
  logic [DIM_W-1:0]  out_col_r, out_col_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;

  logic [RATE_W-1:0] in_rate;
  logic [VAL_W-1:0]  in_start;
  logic [VAL_W-1:0]  op_a;
  logic [VAL_W-1:0]  op_b;
  logic [XC_W-1:0]   x_cand;
  logic [Y_W-1:0]    y_full;
  logic [RATE_W:0]   rem_sh;
  logic              rem_ge;
  logic              in_acc;

  lmbp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  assign in_tready = ctl.in_ready;
  assign in_acc    = in_tvalid && in_tready;

  assign in_rate  = (in_tdata[31:0] > RATE_MAX) ? RATE_MAX : in_tdata[31:0];
  assign in_start = (in_tdata[63:32] > VALUE_ONE) ? VALUE_ONE : in_tdata[63:32];

  assign x_cand = prod_r[PROD_W-1:RATE_FRACTION_BITS];
  assign y_full = prod_r[VALUE_FRACTION_BITS +: Y_W];
  assign rem_sh = {rem_r, dvd_r[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  always_comb begin
    status.in_valid  = in_tvalid;
    status.out_busy  = out_tvalid_r && !out_tready;
    status.iter_done = !(cnt_r < iter_count_r);
    status.iter_more = ({1'b0, cnt_r} + 1'b1) < {1'b0, iter_count_r};
    status.y_zero    = (y_full == '0);
    status.col_zero  = (rate_end_r <= rate_start_r) || (a_r < rate_start_r);
    status.div_more  = (cnt_r != ITER_W'(1));
  end

  // configuration registers
  always_comb begin
    iter_count_nxt = iter_count_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    rate_start_nxt = rate_start_r;
    rate_end_nxt   = rate_end_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ITER_COUNT:   iter_count_nxt = cfg_wdata[ITER_W-1:0];
        REG_IMAGE_WIDTH:  width_nxt      = cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_nxt     = cfg_wdata[DIM_W-1:0];
        REG_RATE_START:   rate_start_nxt = cfg_wdata[RATE_W-1:0];
        REG_RATE_END:     rate_end_nxt   = cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    case (ctl.mul_sel)
      MUL_XMX: begin
        op_a = x_r;
        op_b = VALUE_ONE - x_r;
      end
      MUL_AP: begin
        op_a = a_r;
        op_b = prod_r[VALUE_FRACTION_BITS +: VAL_W];
      end
      MUL_HX: begin
        op_a = VAL_W'(height_r);
        op_b = x_r;
      end
      MUL_WA: begin
        op_a = VAL_W'(width_r);
        op_b = a_r - rate_start_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    x_nxt    = x_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    y_nxt    = y_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    col_nxt  = col_r;

    if (ctl.ld_in) begin
      a_nxt = in_rate;
      x_nxt = in_start;
    end
    if (ctl.ld_x) begin
      x_nxt = (x_cand > XC_W'(VALUE_ONE)) ? VALUE_ONE : x_cand[VAL_W-1:0];
    end
    if (ctl.mul_sel != MUL_NONE) begin
      prod_nxt = {{(PROD_W-VAL_W){1'b0}}, op_a} * {{(PROD_W-VAL_W){1'b0}}, op_b};
    end

    case (ctl.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_ONE:  cnt_nxt = ITER_W'(1);
      CNT_INC:  cnt_nxt = cnt_r + 1'b1;
      CNT_DIV:  cnt_nxt = DIV_STEPS;
      CNT_DEC:  cnt_nxt = cnt_r - 1'b1;
      default:  cnt_nxt = cnt_r;
    endcase

    if (ctl.ld_y) begin
      y_nxt = (y_full > Y_W'(height_r)) ? height_r : y_full[DIM_W-1:0];
    end
    if (ctl.ld_den) begin
      den_nxt = rate_end_r - rate_start_r;
    end
    if (ctl.clr_q) begin
      dvd_nxt = '0;
    end
    if (ctl.ld_dvd) begin
      dvd_nxt = prod_r[NUM_W-1:0];
      rem_nxt = '0;
    end
    if (ctl.div_step) begin
      rem_nxt = rem_ge ? RATE_W'(rem_sh - {1'b0, den_r}) : rem_sh[RATE_W-1:0];
      dvd_nxt = {dvd_r[NUM_W-2:0], rem_ge};
    end
    if (ctl.ld_col) begin
      col_nxt = (dvd_r > NUM_W'(width_r)) ? width_r : dvd_r[DIM_W-1:0];
    end
  end

  // output register
  always_comb begin
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    out_val_nxt = out_val_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
    if (ctl.ld_out) begin
      out_tvalid_nxt = 1'b1;
      out_row_nxt    = height_r - y_r;
      out_col_nxt    = col_r;
      out_val_nxt    = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_count_r <= ITER_COUNT_RST;
      width_r      <= IMAGE_WIDTH_RST;
      height_r     <= IMAGE_HEIGHT_RST;
      rate_start_r <= RATE_START_RST;
      rate_end_r   <= RATE_END_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      iter_count_r <= iter_count_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      rate_start_r <= rate_start_nxt;
      rate_end_r   <= rate_end_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    x_r       <= x_nxt;
    prod_r    <= prod_nxt;
    cnt_r     <= cnt_nxt;
    y_r       <= y_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    col_r     <= col_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_val_r, out_col_r, out_row_r};

  `LMBP_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_tready, "request taken while one is in work")
  `LMBP_ASSERT_NEXT(a_start_clamped, in_acc, x_r <= VALUE_ONE, "start value above one")
  `LMBP_ASSERT_NOW(a_out_slot_free, ctl.ld_out, !out_tvalid_r || out_tready, "result overwritten")
  `LMBP_ASSERT_NOW(a_row_nonzero, ctl.ld_out, y_r != '0, "result emitted for zero height")

endmodule

// ===== hdl/lmbp_seq.sv =====
`timescale 1ns / 1ps

module lmbp_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lmbp_pkg::dp_status_t   status,
  output lmbp_pkg::ctl_word_t    ctl
);
  import lmbp_pkg::*;

  pc_t       pc_r;
  pc_t       pc_nxt;
  ctl_word_t word;
  logic      waiting;
  logic      taken;

  always_comb begin
    word = ucode(pc_r);

    waiting = ((word.wait_on == W_NO_INPUT) && !status.in_valid) ||
              ((word.wait_on == W_OUT_BUSY) && status.out_busy);

    case (word.jump)
      J_NEVER:     taken = 1'b0;
      J_ALWAYS:    taken = 1'b1;
      J_ITER_DONE: taken = status.iter_done;
      J_ITER_MORE: taken = status.iter_more;
      J_Y_ZERO:    taken = status.y_zero;
      J_COL_ZERO:  taken = status.col_zero;
      J_DIV_MORE:  taken = status.div_more;
      default:     taken = 1'b0;
    endcase

    if (waiting) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end

    // hold the datapath while the step waits
    ctl = word;
    if (waiting) begin
      ctl          = CTL_NOP;
      ctl.in_ready = word.in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
